/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries concurrent checks (softmax_normalizer.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the block clock clk_i and reset rst_ni.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/smn_pkg.sv */
// Package for the softmax normalizer: field widths, exp constants, 2^-x table.
`timescale 1ns / 1ps

package smn_pkg;

  // Field widths
  localparam int SCORE_W = 16;  // signed Q8.8 score
  localparam int PROB_W  = 16;  // unsigned Q0.16 probability
  localparam int CLS_W   = 4;   // class index on the result beat
  localparam int CFG_W   = 5;   // num_classes register
  localparam int E_W     = 17;  // exp value, 1.0 = 65536

  // Register reset value
  localparam logic [CFG_W-1:0] NUM_CLASSES_RESET = 5'd5;

  // log2(e) in Q1.16 and the rounding constant for the Q8.8 exponent
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [32:0] ROUND_HALF = 33'd32768;

  // Exponent integer parts above this underflow to zero
  localparam logic [8:0] IP_MAX = 9'd16;

  // 2^(-k/16) in Q1.16
  function automatic logic [E_W-1:0] pow2_neg(input logic [3:0] k);
    logic [E_W-1:0] v;
    unique case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd62757;
      4'd2:    v = 17'd60097;
      4'd3:    v = 17'd57549;
      4'd4:    v = 17'd55109;
      4'd5:    v = 17'd52773;
      4'd6:    v = 17'd50535;
      4'd7:    v = 17'd48393;
      4'd8:    v = 17'd46341;
      4'd9:    v = 17'd44376;
      4'd10:   v = 17'd42495;
      4'd11:   v = 17'd40693;
      4'd12:   v = 17'd38968;
      4'd13:   v = 17'd37316;
      4'd14:   v = 17'd35734;
      default: v = 17'd34219;
    endcase
    return v;
  endfunction

endpackage

/* rtl/smn_ifs.sv */
// Valid/ready channel interfaces for scores, probabilities and configuration.
`timescale 1ns / 1ps

// Score channel: one signed Q8.8 score per beat
interface smn_score_if import smn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

// Result channel: one probability per beat
interface smn_prob_if import smn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic [CLS_W-1:0]  class_index;
  logic              last;
  modport source (output valid, output probability, output class_index, output last,
                  input ready);
  modport sink   (input valid, input probability, input class_index, input last,
                  output ready);
endinterface

// Configuration write channel: num_classes register
interface smn_cfg_if import smn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_classes;
  modport source (output valid, output num_classes, input ready);
  modport sink   (input valid, input num_classes, output ready);
endinterface

/* rtl/softmax_normalizer.sv */
// Top level: fixed-point softmax over one row of class scores, with the row maximum (floored at zero) subtracted.
//
//   channel  | dir | payload                              | beat
//   ---------+-----+--------------------------------------+----------------------
//   cfg_i    | in  | num_classes[4:0]                     | register write
//   score_i  | in  | score[15:0] signed Q8.8              | one class score
//   prob_o   | out | probability[15:0], class_index, last | one class probability
//
// Loading writes each score into the score memory. On the row's last score an exp pass
// reads the score memory once per class through the exp pipeline, then each class takes
// one read, three exp stages, 16 restoring divide steps and an output load; the divide
// steps are skipped when the sum is zero or the class holds all of it. The output load
// waits while an earlier result is still held unaccepted in the output register.
// Reset clears all control state; the score memory needs no clearing.
// A stalled result holds in the output register; the next row loads meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module softmax_normalizer import smn_pkg::*; #(
  parameter int MAX_CLASSES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smn_cfg_if.sink     cfg_i,
  smn_score_if.sink   score_i,
  smn_prob_if.source  prob_o
);

  localparam int AW    = $clog2(MAX_CLASSES);
  localparam int CW    = $clog2(MAX_CLASSES + 1);
  localparam int NW    = (CW > CFG_W) ? CW : CFG_W;
  localparam int SUM_W = E_W + AW;
  localparam int STEP_W = $clog2(PROB_W);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM,
    ST_ISSUE,
    ST_WAIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic [CFG_W-1:0]          num_classes_q;
  logic [CW-1:0]             load_cnt_q;
  logic signed [SCORE_W-1:0] max_q;
  logic [SUM_W-1:0]          sum_q;
  logic [CW-1:0]             issue_q;
  logic [CW-1:0]             acc_q;
  logic [CW-1:0]             cls_q;
  logic [SUM_W-1:0]          rem_q;
  logic [PROB_W-1:0]         quot_q;
  logic [STEP_W-1:0]         step_q;

  // output register
  logic                      out_valid_q;
  logic [PROB_W-1:0]         prob_q;
  logic [CLS_W-1:0]          cls_idx_q;
  logic                      last_q;

  // handshakes; a register write wins over a score in the same cycle
  logic cfg_fire, in_fire;
  assign cfg_i.ready   = (state_q == ST_LOAD);
  assign score_i.ready = (state_q == ST_LOAD) && !cfg_i.valid;
  assign cfg_fire      = cfg_i.valid && cfg_i.ready;
  assign in_fire       = score_i.valid && score_i.ready;

  // clamp the class count to 1..MAX_CLASSES
  logic [NW-1:0] nc_w;
  logic [CW-1:0] row_len;
  assign nc_w = NW'(num_classes_q);
  always_comb begin
    if (nc_w == '0) begin
      row_len = CW'(1);
    end else if (nc_w > NW'(MAX_CLASSES)) begin
      row_len = CW'(MAX_CLASSES);
    end else begin
      row_len = CW'(nc_w);
    end
  end

  // ---------------------------------------------------------------------------
  // Score memory: written while loading, read only in the later passes, so a
  // write and a read never meet on the same entry.
  // ---------------------------------------------------------------------------
  logic signed [SCORE_W-1:0] mem [MAX_CLASSES];
  logic signed [SCORE_W-1:0] mem_rd_q;
  logic                      mem_we;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;

  assign mem_we  = in_fire;
  assign rd_en   = ((state_q == ST_SUM) && (issue_q < row_len)) || (state_q == ST_ISSUE);
  assign rd_addr = (state_q == ST_SUM) ? issue_q[AW-1:0] : cls_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[load_cnt_q[AW-1:0]] <= score_i.score;
    end
    if (rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Exp pipeline: read data -> (max - score) * log2(e) -> table and shift
  // ---------------------------------------------------------------------------
  logic              rv_q, pv_q, ev_q;
  logic signed [16:0] diff;
  logic [15:0]       neg;
  logic [32:0]       prod_d, prod_q;
  logic [32:0]       rnd;
  logic [16:0]       m_exp;
  logic [8:0]        ip;
  logic [E_W-1:0]    e_d, e_q;

  assign diff   = 17'(max_q) - 17'(mem_rd_q);
  assign neg    = diff[15:0];  // max never below the score, so 0..65535
  assign prod_d = 33'(neg) * 33'(LOG2E_Q16);
  assign rnd    = prod_q + ROUND_HALF;
  assign m_exp  = rnd[32:16];
  assign ip     = m_exp[16:8];
  assign e_d    = (ip > IP_MAX) ? '0 : (pow2_neg(m_exp[7:4]) >> ip[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      pv_q <= 1'b0;
      ev_q <= 1'b0;
    end else begin
      rv_q <= rd_en;
      pv_q <= rv_q;
      ev_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    e_q    <= e_d;
  end

  // ---------------------------------------------------------------------------
  // Restoring divide step: one quotient bit per cycle, remainder below the sum
  // ---------------------------------------------------------------------------
  logic [SUM_W:0]   rem_sh;
  logic             q_bit;
  logic [SUM_W-1:0] rem_nxt;
  assign rem_sh  = {rem_q, 1'b0};
  assign q_bit   = (rem_sh >= {1'b0, sum_q});
  assign rem_nxt = q_bit ? SUM_W'(rem_sh - {1'b0, sum_q}) : SUM_W'(rem_sh);

  logic emit_go, last_cls;
  assign emit_go  = !out_valid_q || prob_o.ready;
  assign last_cls = (CW'(cls_q + 1'b1) == row_len);

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      num_classes_q <= NUM_CLASSES_RESET;
      load_cnt_q    <= '0;
      max_q         <= '0;
      sum_q         <= '0;
      issue_q       <= '0;
      acc_q         <= '0;
      cls_q         <= '0;
      step_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // result taken; while emitting, the output load below decides
      if (out_valid_q && prob_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_LOAD: begin
          if (cfg_fire) begin
            // a new class count drops any partial row
            num_classes_q <= cfg_i.num_classes;
            load_cnt_q    <= '0;
            max_q         <= '0;
            sum_q         <= '0;
          end else if (in_fire) begin
            if (score_i.score > max_q) begin
              max_q <= score_i.score;
            end
            if (CW'(load_cnt_q + 1'b1) == row_len) begin
              load_cnt_q <= '0;
              issue_q    <= '0;
              acc_q      <= '0;
              sum_q      <= '0;
              state_q    <= ST_SUM;
            end else begin
              load_cnt_q <= CW'(load_cnt_q + 1'b1);
            end
          end
        end

        // exp pass: stream reads, accumulate as results leave the pipeline
        ST_SUM: begin
          if (rd_en) begin
            issue_q <= CW'(issue_q + 1'b1);
          end
          if (ev_q) begin
            sum_q <= SUM_W'(sum_q + SUM_W'(e_q));
            if (CW'(acc_q + 1'b1) == row_len) begin
              cls_q   <= '0;
              state_q <= ST_ISSUE;
            end else begin
              acc_q <= CW'(acc_q + 1'b1);
            end
          end
        end

        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end

        // exp of this class ready: pick zero, saturated or divided result
        ST_WAIT: begin
          if (ev_q) begin
            step_q <= '0;
            if (sum_q == '0) begin
              quot_q  <= '0;
              state_q <= ST_EMIT;
            end else if (SUM_W'(e_q) >= sum_q) begin
              quot_q  <= '1;
              state_q <= ST_EMIT;
            end else begin
              quot_q  <= '0;
              rem_q   <= SUM_W'(e_q);
              state_q <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          rem_q  <= rem_nxt;
          quot_q <= {quot_q[PROB_W-2:0], q_bit};
          step_q <= STEP_W'(step_q + 1'b1);
          if (step_q == STEP_W'(PROB_W - 1)) begin
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            prob_q      <= quot_q;
            cls_idx_q   <= CLS_W'(cls_q);
            last_q      <= last_cls;
            if (last_cls) begin
              max_q   <= '0;
              sum_q   <= '0;
              state_q <= ST_LOAD;
            end else begin
              cls_q   <= CW'(cls_q + 1'b1);
              state_q <= ST_ISSUE;
            end
          end
        end

        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign prob_o.valid       = out_valid_q;
  assign prob_o.probability = prob_q;
  assign prob_o.class_index = cls_idx_q;
  assign prob_o.last        = last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_STD(a_mem_one_port, !(mem_we && rd_en), "score memory written and read together")
  `ASSERT_STD(a_sum_order, (state_q == ST_SUM) |-> (acc_q <= issue_q),
              "exp pass accumulated more than it read")
  `ASSERT_STD(a_div_rem, (state_q == ST_DIV) |-> (rem_q < sum_q),
              "divider remainder not below the sum")
  `ASSERT_STD(a_exp_owner, ev_q |-> (state_q == ST_SUM || state_q == ST_WAIT),
              "exp result arrived with no pass waiting for it")
  `ASSERT_STD(a_row_done, (state_q == ST_EMIT && emit_go && last_cls) |=>
              (state_q == ST_LOAD && max_q == '0 && out_valid_q && last_q),
              "row end did not return to loading with a last beat")

endmodule
